// File: rtl/tcpho_pkg.sv
package tcpho_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CountW    = PtrW + 1;

  localparam logic [5:0] FixedHdrLen = 6'd20;
  localparam logic [3:0] MinHdrWords = 4'd5;

  // Field codes of a result word.
  localparam logic [4:0] FC_SRC      = 5'd0;
  localparam logic [4:0] FC_DST      = 5'd1;
  localparam logic [4:0] FC_SEQ      = 5'd2;
  localparam logic [4:0] FC_ACK      = 5'd3;
  localparam logic [4:0] FC_OFFSET   = 5'd4;
  localparam logic [4:0] FC_FLAGS    = 5'd5;
  localparam logic [4:0] FC_WINDOW   = 5'd6;
  localparam logic [4:0] FC_CHECKSUM = 5'd7;
  localparam logic [4:0] FC_URGENT   = 5'd8;
  localparam logic [4:0] FC_NOP      = 5'd9;
  localparam logic [4:0] FC_MSS      = 5'd10;
  localparam logic [4:0] FC_SCALE    = 5'd11;
  localparam logic [4:0] FC_SACKPERM = 5'd12;
  localparam logic [4:0] FC_SACK     = 5'd13;
  localparam logic [4:0] FC_TSVAL    = 5'd14;
  localparam logic [4:0] FC_TSECR    = 5'd15;
  localparam logic [4:0] FC_HDR_END  = 5'd16;

  // Status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_UNKNOWN_OPT = 3'd1;
  localparam logic [2:0] ST_TRUNCATED   = 3'd2;
  localparam logic [2:0] ST_BAD_OFFSET  = 3'd3;
  localparam logic [2:0] ST_BAD_OPT_LEN = 3'd4;

  // Option kinds.
  localparam logic [7:0] OPT_EOL      = 8'd0;
  localparam logic [7:0] OPT_NOP      = 8'd1;
  localparam logic [7:0] OPT_MSS      = 8'd2;
  localparam logic [7:0] OPT_SCALE    = 8'd3;
  localparam logic [7:0] OPT_SACKPERM = 8'd4;
  localparam logic [7:0] OPT_SACK     = 8'd5;
  localparam logic [7:0] OPT_TSTAMP   = 8'd8;

  typedef struct packed {
    logic [4:0]  code;
    logic [31:0] value;
    logic [5:0]  start;
    logic [5:0]  length;
    logic [2:0]  status;
    logic        eor;
  } rec_t;

  // Up to two result words written into the output queue in one cycle.
  typedef struct packed {
    logic v0;
    logic v1;
    rec_t r0;
    rec_t r1;
  } push_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] code;
    logic [5:0] start;
    logic [5:0] length;
  } fixed_field_t;

  // Fixed header fields that complete on the given byte position.
  function automatic fixed_field_t fixed_field(input logic [5:0] p);
    fixed_field_t f;
    f = '0;
    unique case (p)
      6'd1:    f = '{1'b1, FC_SRC,      6'd0,  6'd2};
      6'd3:    f = '{1'b1, FC_DST,      6'd2,  6'd2};
      6'd7:    f = '{1'b1, FC_SEQ,      6'd4,  6'd4};
      6'd11:   f = '{1'b1, FC_ACK,      6'd8,  6'd4};
      6'd15:   f = '{1'b1, FC_WINDOW,   6'd14, 6'd2};
      6'd17:   f = '{1'b1, FC_CHECKSUM, 6'd16, 6'd2};
      6'd19:   f = '{1'b1, FC_URGENT,   6'd18, 6'd2};
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// File: rtl/tcpho_in_if.sv
interface tcpho_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: rtl/tcpho_out_if.sv
interface tcpho_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  field_code;
  logic [31:0] field_value;
  logic [5:0]  field_start;
  logic [5:0]  field_length;
  logic [2:0]  status;
  logic        end_of_run;

  modport source (output valid, output field_code, output field_value, output field_start,
                  output field_length, output status, output end_of_run, input ready);
  modport sink   (input valid, input field_code, input field_value, input field_start,
                  input field_length, input status, input end_of_run, output ready);
endinterface

// File: rtl/tcpho_core.sv
module tcpho_core
  import tcpho_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output push_t      push_o
);

  logic [5:0]  pos_q, pos_d;
  logic        past_q, past_d;
  logic [31:0] acc_q, acc_d;
  logic [3:0]  hlw_q, hlw_d;
  logic        ns_q, ns_d;
  logic [7:0]  okind_q, okind_d;
  logic [5:0]  ostart_q, ostart_d;
  logic [7:0]  olen_q, olen_d;
  logic        ostop_q, ostop_d;
  logic [2:0]  err_q, err_d;

  logic [5:0]   hlen;
  logic [31:0]  acc_n;
  logic [5:0]   rel;
  logic [6:0]   need;
  logic         stop_req;
  logic [2:0]   stop_err;
  fixed_field_t ff;
  push_t        push;

  assign hlen  = (hlw_q < MinHdrWords) ? FixedHdrLen : {hlw_q, 2'b00};
  assign acc_n = {acc_q[23:0], byte_i};
  assign rel   = pos_q - ostart_q;
  assign ff    = fixed_field(pos_q);

  always_comb begin
    pos_d    = pos_q;
    past_d   = past_q;
    acc_d    = acc_q;
    hlw_d    = hlw_q;
    ns_d     = ns_q;
    okind_d  = okind_q;
    ostart_d = ostart_q;
    olen_d   = olen_q;
    ostop_d  = ostop_q;
    err_d    = err_q;
    need     = '0;
    stop_req = 1'b0;
    stop_err = ST_OK;
    push     = '0;

    if (!past_q) begin
      if (pos_q < FixedHdrLen) begin
        if (pos_q == 6'd12) begin
          hlw_d   = byte_i[7:4];
          ns_d    = byte_i[0];
          push.v0 = 1'b1;
          push.r0 = '{FC_OFFSET, {28'd0, byte_i[7:4]}, 6'd12, 6'd1,
                      (byte_i[7:4] < MinHdrWords) ? ST_BAD_OFFSET : ST_OK, 1'b0};
          if (byte_i[7:4] < MinHdrWords && err_q == ST_OK) begin
            err_d = ST_BAD_OFFSET;
          end
        end else if (pos_q == 6'd13) begin
          push.v0 = 1'b1;
          push.r0 = '{FC_FLAGS, {23'd0, ns_q, byte_i}, 6'd12, 6'd2, ST_OK, 1'b0};
        end else begin
          acc_d = acc_n;
          if (ff.hit) begin
            push.v0 = 1'b1;
            push.r0 = '{ff.code, acc_n, ff.start, ff.length, ST_OK, 1'b0};
            acc_d   = '0;
          end
        end
      end else if (!ostop_q) begin
        if (olen_q == 8'd0) begin
          // First byte of an option: its kind.
          ostart_d = pos_q;
          acc_d    = '0;
          unique case (byte_i)
            OPT_EOL:      stop_req = 1'b1;
            OPT_NOP: begin
              push.v0 = 1'b1;
              push.r0 = '{FC_NOP, 32'd0, pos_q, 6'd1, ST_OK, 1'b0};
            end
            OPT_MSS:      need = 7'd4;
            OPT_SCALE:    need = 7'd3;
            OPT_SACKPERM: need = 7'd2;
            OPT_SACK:     need = 7'd2;
            OPT_TSTAMP:   need = 7'd10;
            default: begin
              stop_req = 1'b1;
              stop_err = ST_UNKNOWN_OPT;
            end
          endcase
          if (need != 7'd0) begin
            if ({1'b0, pos_q} + need > {1'b0, hlen}) begin
              stop_req = 1'b1;
              stop_err = ST_BAD_OPT_LEN;
            end else begin
              okind_d = byte_i;
              olen_d  = {1'b0, need};
            end
          end
        end else begin
          acc_d = acc_n;
          unique case (okind_q)
            OPT_MSS: begin
              if (rel == 6'd3) begin
                push.v0 = 1'b1;
                push.r0 = '{FC_MSS, {16'd0, acc_n[15:0]}, ostart_q, 6'd4, ST_OK, 1'b0};
              end
            end
            OPT_SCALE: begin
              if (rel == 6'd2) begin
                push.v0 = 1'b1;
                push.r0 = '{FC_SCALE, {24'd0, byte_i}, ostart_q, 6'd3, ST_OK, 1'b0};
              end
            end
            OPT_SACKPERM: begin
              if (rel == 6'd1) begin
                push.v0 = 1'b1;
                push.r0 = '{FC_SACKPERM, 32'd1, ostart_q, 6'd2, ST_OK, 1'b0};
              end
            end
            OPT_SACK: begin
              if (rel == 6'd1) begin
                // The declared length must cover kind and length bytes and stay
                // inside the header.
                if (byte_i < 8'd2 || {3'd0, ostart_q} + {1'b0, byte_i} > {3'd0, hlen}) begin
                  stop_req = 1'b1;
                  stop_err = ST_BAD_OPT_LEN;
                end else begin
                  olen_d  = byte_i;
                  push.v0 = 1'b1;
                  push.r0 = '{FC_SACK, 32'd0, ostart_q, byte_i[5:0], ST_OK, 1'b0};
                end
              end
            end
            OPT_TSTAMP: begin
              if (rel == 6'd5) begin
                push.v0 = 1'b1;
                push.r0 = '{FC_TSVAL, acc_n, ostart_q + 6'd2, 6'd4, ST_OK, 1'b0};
                acc_d   = '0;
              end else if (rel == 6'd9) begin
                push.v0 = 1'b1;
                push.r0 = '{FC_TSECR, acc_n, ostart_q + 6'd6, 6'd4, ST_OK, 1'b0};
              end
            end
            default: ;
          endcase
          if (!stop_req && ({2'b00, rel} + 8'd1 >= olen_d)) begin
            olen_d = '0;
          end
        end
      end

      if (stop_req) begin
        if (stop_err != ST_OK && err_q == ST_OK) begin
          err_d = stop_err;
        end
        ostop_d = 1'b1;
        olen_d  = '0;
      end

      if (pos_q >= 6'd19 && ({1'b0, pos_q} + 7'd1 == {1'b0, hlen})) begin
        push.v1 = 1'b1;
        push.r1 = '{FC_HDR_END, {26'd0, hlen}, 6'd0, 6'd0, err_d, 1'b1};
        past_d  = 1'b1;
      end else if (last_i) begin
        push.v1 = 1'b1;
        push.r1 = '{FC_HDR_END, {25'd0, {1'b0, pos_q} + 7'd1}, 6'd0, 6'd0,
                    (err_d != ST_OK) ? err_d : ST_TRUNCATED, 1'b1};
        past_d  = 1'b1;
      end else begin
        pos_d = pos_q + 6'd1;
      end
    end

    // The record in slot 0 closes the run only when no header end follows it.
    push.r0.eor = ~push.v1;

    if (last_i) begin
      pos_d    = '0;
      past_d   = 1'b0;
      acc_d    = '0;
      hlw_d    = '0;
      ns_d     = 1'b0;
      okind_d  = '0;
      ostart_d = '0;
      olen_d   = '0;
      ostop_d  = 1'b0;
      err_d    = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      past_q   <= 1'b0;
      acc_q    <= '0;
      hlw_q    <= '0;
      ns_q     <= 1'b0;
      okind_q  <= '0;
      ostart_q <= '0;
      olen_q   <= '0;
      ostop_q  <= 1'b0;
      err_q    <= ST_OK;
    end else if (take_i) begin
      pos_q    <= pos_d;
      past_q   <= past_d;
      acc_q    <= acc_d;
      hlw_q    <= hlw_d;
      ns_q     <= ns_d;
      okind_q  <= okind_d;
      ostart_q <= ostart_d;
      olen_q   <= olen_d;
      ostop_q  <= ostop_d;
      err_q    <= err_d;
    end
  end

  assign push_o.v0 = take_i & push.v0;
  assign push_o.v1 = take_i & push.v1;
  assign push_o.r0 = push.r0;
  assign push_o.r1 = push.r1;

  a_second_is_hdr_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.v1 |-> (push_o.r1.code == FC_HDR_END) && push_o.r1.eor)
    else $error("second result slot must carry the header end");

  a_no_output_past_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    past_q |-> !push.v0 && !push.v1)
    else $error("result produced after the header end");

endmodule

// File: rtl/tcpho_fifo.sv
module tcpho_fifo
  import tcpho_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room2_o,
  output logic  valid_o,
  input  logic  ready_i,
  output rec_t  head_o
);

  rec_t              mem_q [FifoDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CountW-1:0] count_q;
  logic              pop;
  logic [CountW-1:0] n_push;

  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_q];
  assign pop     = valid_o & ready_i;
  assign room2_o = (count_q <= CountW'(FifoDepth - 2));
  assign n_push  = CountW'(push_i.v0) + CountW'(push_i.v1);

  // Slot 1 alone lands at the write pointer; with slot 0 it goes one above.
  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wr_q] <= push_i.r0;
      if (push_i.v1) begin
        mem_q[wr_q + PtrW'(1)] <= push_i.r1;
      end
    end else if (push_i.v1) begin
      mem_q[wr_q] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + n_push[PtrW-1:0];
      rd_q    <= rd_q + PtrW'(pop);
      count_q <= count_q + n_push - CountW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.v0 || push_i.v1) |-> room2_o)
    else $error("result queue written without room");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(FifoDepth))
    else $error("result queue count out of range");

  a_pop_moves_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> rd_q == $past(rd_q) + PtrW'(1))
    else $error("read pointer did not advance on a pop");

endmodule

// File: rtl/tcp_header_option_parser_top.sv
// TCP header and option decoder.
//
// The in_i channel carries one segment byte per word (data_byte) with
// last_byte marking the final byte of a segment. The out_o channel carries
// one decoded field per word: field_code, field_value, field_start,
// field_length, status and end_of_run, which marks the last word caused by
// a given input byte. A byte gives at most two words: a field or option and
// the header-end word that follows it. Bytes after the header give nothing.
//
// An accepted byte is held in the input register and decoded from there, waiting
// while the result queue lacks room for two words; its words enter the queue at
// the edge that takes the byte, and the first shows on out_o once earlier words drain.
// One byte is taken per cycle while the four-word result queue has room for
// two words, so bytes whose words are drained at once stream at full rate;
// bytes that give two words each drain at one word per cycle.
//
// Reset clears the decoder to the start of a segment and empties the queue.
// When the receiver stalls, the queue fills and in_i.ready drops until there
// is room again; no word is lost or repeated.
module tcp_header_option_parser_top
  import tcpho_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tcpho_in_if.sink    in_i,
  tcpho_out_if.source out_o
);

  logic       in_vq;
  logic [7:0] byte_q;
  logic       last_q;
  logic       room2;
  logic       take;
  push_t      push;
  rec_t       head;

  assign take       = in_vq & room2;
  assign in_i.ready = ~in_vq | take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_i.ready) begin
      in_vq <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      byte_q <= in_i.data_byte;
      last_q <= in_i.last_byte;
    end
  end

  tcpho_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (byte_q),
    .last_i (last_q),
    .push_o (push)
  );

  tcpho_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room2_o (room2),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .head_o  (head)
  );

  assign out_o.field_code   = head.code;
  assign out_o.field_value  = head.value;
  assign out_o.field_start  = head.start;
  assign out_o.field_length = head.length;
  assign out_o.status       = head.status;
  assign out_o.end_of_run   = head.eor;

  a_stall_without_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vq && !room2) |-> !in_i.ready)
    else $error("input taken while the decoder is stalled");

endmodule

// File: verif/tb_tcp_header_option_parser_top.sv
module tb_tcp_header_option_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcpho_pkg::*;

  localparam int unsigned ByteTarget = 1850;
  localparam int unsigned QuietFrom  = 1600;
  localparam int unsigned CycleLimit = 400000;

  // Decodes the segment byte stream alongside the block and holds the field
  // words that are still due on the output channel.
  class header_field_checker;
    rec_t        due_fields[$];
    int unsigned bytes_taken;
    int unsigned mismatches;

    logic [5:0]  pos;
    logic        past_hdr;
    logic [31:0] acc;
    logic [3:0]  hwords;
    logic        ns;
    logic [7:0]  okind;
    logic [5:0]  ostart;
    logic [7:0]  olen;
    logic        stopped;
    logic [2:0]  err;

    function new();
      bytes_taken = 0;
      mismatches  = 0;
      clear_segment();
    endfunction

    function void clear_segment();
      pos      = '0;
      past_hdr = 1'b0;
      acc      = '0;
      hwords   = '0;
      ns       = 1'b0;
      okind    = '0;
      ostart   = '0;
      olen     = '0;
      stopped  = 1'b0;
      err      = ST_OK;
    endfunction

    function int unsigned hdr_len();
      return (hwords < MinHdrWords) ? int'(FixedHdrLen) : int'(hwords) * 4;
    endfunction

    function void emit(logic [4:0] c, logic [31:0] v, int unsigned s, int unsigned l,
                       logic [2:0] st);
      rec_t r;
      r.code   = c;
      r.value  = v;
      r.start  = s[5:0];
      r.length = l[5:0];
      r.status = st;
      r.eor    = 1'b0;
      due_fields.push_back(r);
    endfunction

    function void stop_options(logic [2:0] why);
      if (why != ST_OK && err == ST_OK) err = why;
      stopped = 1'b1;
      olen    = '0;
    endfunction

    function void option_byte(int unsigned p, logic [7:0] b, int unsigned hl);
      int unsigned need;
      int unsigned rel;
      if (stopped) return;
      if (olen == 0) begin
        ostart = p[5:0];
        acc    = '0;
        need   = 0;
        case (b)
          OPT_EOL: begin
            stop_options(ST_OK);
            return;
          end
          OPT_NOP: begin
            emit(FC_NOP, '0, p, 1, ST_OK);
            return;
          end
          OPT_MSS:      need = 4;
          OPT_SCALE:    need = 3;
          OPT_SACKPERM: need = 2;
          OPT_SACK:     need = 2;
          OPT_TSTAMP:   need = 10;
          default: begin
            stop_options(ST_UNKNOWN_OPT);
            return;
          end
        endcase
        if (p + need > hl) begin
          stop_options(ST_BAD_OPT_LEN);
          return;
        end
        okind = b;
        olen  = need[7:0];
        return;
      end
      rel = p - int'(ostart);
      acc = {acc[23:0], b};
      case (okind)
        OPT_MSS:
          if (rel == 3) emit(FC_MSS, {16'h0, acc[15:0]}, ostart, 4, ST_OK);
        OPT_SCALE:
          if (rel == 2) emit(FC_SCALE, 32'(b), ostart, 3, ST_OK);
        OPT_SACKPERM:
          if (rel == 1) emit(FC_SACKPERM, 32'd1, ostart, 2, ST_OK);
        OPT_SACK:
          if (rel == 1) begin
            if (b < 8'd2 || int'(ostart) + int'(b) > hl) begin
              stop_options(ST_BAD_OPT_LEN);
              return;
            end
            olen = b;
            emit(FC_SACK, '0, ostart, b, ST_OK);
          end
        OPT_TSTAMP:
          if (rel == 5) begin
            emit(FC_TSVAL, acc, int'(ostart) + 2, 4, ST_OK);
            acc = '0;
          end else if (rel == 9) begin
            emit(FC_TSECR, acc, int'(ostart) + 6, 4, ST_OK);
          end
        default: ;
      endcase
      if (rel + 1 >= olen) olen = '0;
    endfunction

    // Works out the words that one accepted byte gives and queues them.
    function void decode_byte(logic [7:0] b, logic fin);
      int unsigned p;
      int unsigned hl;
      int unsigned n0;
      n0 = due_fields.size();
      bytes_taken++;
      if (!past_hdr) begin
        p  = pos;
        hl = hdr_len();
        if (p < 20) begin
          if (p == 12) begin
            hwords = b[7:4];
            ns     = b[0];
            emit(FC_OFFSET, 32'(hwords), 12, 1,
                 (hwords < MinHdrWords) ? ST_BAD_OFFSET : ST_OK);
            if (hwords < MinHdrWords && err == ST_OK) err = ST_BAD_OFFSET;
            hl = hdr_len();
          end else if (p == 13) begin
            emit(FC_FLAGS, 32'({ns, b}), 12, 2, ST_OK);
          end else begin
            acc = {acc[23:0], b};
            case (p)
              1:  emit(FC_SRC,      acc, 0,  2, ST_OK);
              3:  emit(FC_DST,      acc, 2,  2, ST_OK);
              7:  emit(FC_SEQ,      acc, 4,  4, ST_OK);
              11: emit(FC_ACK,      acc, 8,  4, ST_OK);
              15: emit(FC_WINDOW,   acc, 14, 2, ST_OK);
              17: emit(FC_CHECKSUM, acc, 16, 2, ST_OK);
              19: emit(FC_URGENT,   acc, 18, 2, ST_OK);
              default: ;
            endcase
            if (p inside {1, 3, 7, 11, 15, 17, 19}) acc = '0;
          end
        end else begin
          option_byte(p, b, hl);
        end

        if (p >= 19 && p + 1 == hl) begin
          emit(FC_HDR_END, hl, 0, 0, err);
          past_hdr = 1'b1;
        end else if (fin) begin
          emit(FC_HDR_END, p + 1, 0, 0, (err != ST_OK) ? err : ST_TRUNCATED);
          past_hdr = 1'b1;
        end else begin
          pos = 6'(p + 1);
        end
      end
      if (due_fields.size() > n0) due_fields[due_fields.size() - 1].eor = 1'b1;
      if (fin) clear_segment();
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= 30) $display("%0t: mismatch: %s", $realtime, msg);
    endtask

    task check_word(rec_t got);
      rec_t want;
      if (due_fields.size() == 0) begin
        flag_mismatch($sformatf("unexpected word code %0d value %h start %0d",
                                got.code, got.value, got.start));
        return;
      end
      want = due_fields.pop_front();
      if (got.code !== want.code || got.value !== want.value ||
          got.start !== want.start || got.length !== want.length ||
          got.status !== want.status || got.eor !== want.eor)
        flag_mismatch($sformatf(
          "got code %0d val %h start %0d len %0d st %0d eor %b, want %0d %h %0d %0d %0d %b",
          got.code, got.value, got.start, got.length, got.status, got.eor,
          want.code, want.value, want.start, want.length, want.status, want.eor));
    endtask
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tcpho_in_if  in_if ();
  tcpho_out_if out_if ();

  tcp_header_option_parser_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  header_field_checker chk;
  logic [7:0]          seg_q[$];
  bit                  tx_gaps;
  bit                  rx_stalls;

  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic void fill(int unsigned n);
    repeat (n) seg_q.push_back(8'($urandom));
  endfunction

  // A fixed-size option; when it does not fit, the rest of the header is junk.
  function automatic void add_fixed(logic [7:0] kind, int unsigned size,
                                    ref int unsigned room);
    seg_q.push_back(kind);
    if (size > room) begin
      fill(room - 1);
      room = 0;
      return;
    end
    seg_q.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(size));
    fill(size - 2);
    room -= size;
  endfunction

  function automatic void build_segment();
    int unsigned words;
    int unsigned room;
    int unsigned pick;
    int unsigned len;
    seg_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      fill($urandom_range(1, 66));
      return;
    end
    for (int i = 0; i < 20; i++) seg_q.push_back(rand_byte());
    pick  = $urandom_range(0, 99);
    words = (pick < 8) ? $urandom_range(0, 4) :
            (pick < 65) ? $urandom_range(5, 8) : $urandom_range(9, 15);
    seg_q[12] = {words[3:0], seg_q[12][3:0]};
    room = (words < 5) ? 0 : words * 4 - 20;
    while (room > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        seg_q.push_back(OPT_NOP);
        room--;
      end else if (pick < 30) begin
        add_fixed(OPT_MSS, 4, room);
      end else if (pick < 42) begin
        add_fixed(OPT_SCALE, 3, room);
      end else if (pick < 52) begin
        add_fixed(OPT_SACKPERM, 2, room);
      end else if (pick < 70) begin
        add_fixed(OPT_TSTAMP, 10, room);
      end else if (pick < 88) begin
        seg_q.push_back(OPT_SACK);
        pick = $urandom_range(0, 9);
        if (room < 2) begin
          fill(room - 1);
          room = 0;
        end else if (pick == 0) begin
          seg_q.push_back(8'($urandom_range(0, 1)));
          fill(room - 2);
          room = 0;
        end else if (pick == 1) begin
          seg_q.push_back(8'(room + $urandom_range(1, 200)));
          fill(room - 2);
          room = 0;
        end else begin
          len = $urandom_range(2, room);
          seg_q.push_back(8'(len));
          fill(len - 2);
          room -= len;
        end
      end else if (pick < 94) begin
        seg_q.push_back(OPT_EOL);
        fill(room - 1);
        room = 0;
      end else begin
        seg_q.push_back((pick < 97) ? 8'($urandom_range(6, 7)) : 8'($urandom_range(9, 255)));
        fill(room - 1);
        room = 0;
      end
    end
    fill($urandom_range(0, 6));
  endfunction

  task automatic send_byte(logic [7:0] d, logic fin);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= d;
    in_if.last_byte <= fin;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    chk.decode_byte(d, fin);
  endtask

  task automatic send_segment(int unsigned n);
    for (int i = 0; i < n; i++) send_byte(seg_q[i], i == n - 1);
  endtask

  initial begin
    int unsigned cut;
    chk = new();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    in_if.valid     <= 1'b0;
    in_if.data_byte <= '0;
    in_if.last_byte <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A one-byte segment, a full header with a short data offset and NS set,
    // and a segment cut just after the source port.
    seg_q = {8'hFF};
    send_segment(1);
    seg_q.delete();
    repeat (20) seg_q.push_back(8'hFF);
    seg_q[12] = 8'h41;
    send_segment(20);
    seg_q = {8'h00, 8'h00};
    send_segment(2);

    while (chk.bytes_taken < ByteTarget) begin
      build_segment();
      cut = seg_q.size();
      if ($urandom_range(0, 7) == 0) cut = $urandom_range(1, seg_q.size());
      tx_gaps   = (chk.bytes_taken < QuietFrom) && ($urandom_range(0, 4) != 0);
      rx_stalls = (chk.bytes_taken < QuietFrom) && ($urandom_range(0, 4) != 0);
      send_segment(cut);
    end
    in_if.valid <= 1'b0;

    while (chk.due_fields.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (chk.mismatches == 0) begin
      $display("tb_tcp_header_option_parser_top: PASS");
    end else begin
      $display("tb_tcp_header_option_parser_top: FAIL");
    end
    $finish;
  end

  // Output side: checks every word taken and stalls at random. Once, well
  // into the run, it holds off long enough for the block to back up.
  initial begin
    int unsigned hold;
    bit          long_done;
    rec_t        got;
    hold      = 0;
    long_done = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got.code   = out_if.field_code;
        got.value  = out_if.field_value;
        got.start  = out_if.field_start;
        got.length = out_if.field_length;
        got.status = out_if.status;
        got.eor    = out_if.end_of_run;
        chk.check_word(got);
      end
      if (!long_done && chk.bytes_taken >= 300) begin
        long_done = 1'b1;
        hold      = 60;
      end else if (hold == 0 && rx_stalls && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 4);
      end
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_tcp_header_option_parser_top: FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/tcpho_pkg.sv
rtl/tcpho_in_if.sv
rtl/tcpho_out_if.sv
rtl/tcpho_core.sv
rtl/tcpho_fifo.sv
rtl/tcp_header_option_parser_top.sv
verif/tb_tcp_header_option_parser_top.sv
